FILE: sv/ftpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftpc_pkg;

   localparam logic [7:0] START_BYTE = 8'h24;
   localparam logic [7:0] END_BYTE   = 8'h23;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] NET_ON_VAL = 8'h02;
   localparam logic [4:0] LEN_MASK   = 5'h1f;
   localparam int         TYPE_SHIFT = 5;
   localparam logic [8:0] POS_MAX    = 9'd511;

   localparam logic [2:0] FIELD_USER = 3'd0;
   localparam logic [2:0] FIELD_SITE = 3'd1;
   localparam logic [2:0] FIELD_NET  = 3'd4;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_USER   = 2'd1;
   localparam logic [1:0] KIND_SITE   = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FRAMING  = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

   localparam logic [1:0] NET_NONE    = 2'd0;
   localparam logic [1:0] NET_OFF     = 2'd1;
   localparam logic [1:0] NET_ON      = 2'd2;
   localparam logic [1:0] NET_PENDING = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] char_index;
      logic [7:0] char_value;
      logic [1:0] status;
      logic       net_enabled;
      logic       notify_failure;
      logic       last_result;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/ftpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ftpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/framed_tlv_packet_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// framed packet checker: takes one packet byte per transfer (req_data.frame_start marks
// position 0), checks the 0x24 start pair, the 0x23 end pair placed by byte 3 and
// the mod-256 checksum placed by byte 7, and walks type/length fields from byte 8
// to capture the user name, site name and network-enable flag. a byte is taken
// whenever no name burst runs and the output register is free. the last byte yields
// a status result in the output register; on success each captured name follows,
// read back from the name ram: a downward trim scan of up to NAME_CHARS-1 reads and
// then NAME_CHARS reads. input is stalled for that burst.
// no clearing pass: per-entry valid bits drop at each frame start.

module framed_tlv_packet_checker #(
   parameter int NAME_CHARS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ftpc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ftpc_pkg::rsp_type     rsp_data
);

   // index width of one name store and ram geometry (both names share one ram)
   localparam int IW    = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   localparam int SLOTS = 1 << IW;
   localparam int AW    = IW + 1;
   localparam int DEPTH = 2 * SLOTS;
   localparam logic [IW-1:0] LAST_IDX  = IW'(NAME_CHARS - 1);
   localparam logic [4:0]    CHARS_W5  = 5'(NAME_CHARS);

   // burst sequencer codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK = 3'd2;
   localparam logic [2:0] ST_OUT_RD   = 3'd3;
   localparam logic [2:0] ST_OUT_WAIT = 3'd4;

   // per-frame state
   logic [8:0] byte_position_ff, byte_position_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] body_length_ff, body_length_in;
   logic [7:0] byte_six_ff, byte_six_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic       framing_good_ff, framing_good_in;
   logic       checksum_good_ff, checksum_good_in;
   logic [8:0] next_header_ff, next_header_in;
   logic [2:0] field_type_ff, field_type_in;
   logic [4:0] bytes_left_ff, bytes_left_in;
   logic [4:0] write_index_ff, write_index_in;
   logic       zero_written_ff, zero_written_in;
   logic [1:0] names_seen_ff, names_seen_in;
   logic [1:0] staged_net_ff, staged_net_in;
   logic       committed_net_ff, committed_net_in;
   logic       failure_notified_ff, failure_notified_in;
   logic [DEPTH-1:0] entry_valid_ff, entry_valid_in;

   // burst sequencer
   logic [2:0]    state_ff, state_in;
   logic          name_sel_ff, name_sel_in;
   logic [IW-1:0] char_idx_ff, char_idx_in;
   logic [IW-1:0] trim_ff, trim_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   ftpc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ram ports
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   logic [7:0]    stored_char;

   logic out_free;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign ram_rd_addr = {name_sel_ff, char_idx_ff};
   // an entry never written since frame start reads as zero
   assign stored_char = entry_valid_ff[ram_rd_addr] ? ram_rd_data : 8'h00;

   ftpc_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // byte step: framing, checksum, field walk and status
   always_comb begin
      logic [8:0] pos;
      logic [7:0] b;
      logic [8:0] ck;
      logic [8:0] rel;
      logic [2:0] ftype;
      logic [4:0] flen;
      logic [7:0] wval;
      logic [1:0] st;
      logic       notify;
      logic       emit;

      byte_position_in    = byte_position_ff;
      frame_length_in     = frame_length_ff;
      body_length_in      = body_length_ff;
      byte_six_in         = byte_six_ff;
      running_sum_in      = running_sum_ff;
      framing_good_in     = framing_good_ff;
      checksum_good_in    = checksum_good_ff;
      next_header_in      = next_header_ff;
      field_type_in       = field_type_ff;
      bytes_left_in       = bytes_left_ff;
      write_index_in      = write_index_ff;
      zero_written_in     = zero_written_ff;
      names_seen_in       = names_seen_ff;
      staged_net_in       = staged_net_ff;
      committed_net_in    = committed_net_ff;
      failure_notified_in = failure_notified_ff;
      entry_valid_in      = entry_valid_ff;
      ram_wr_en           = 1'b0;
      ram_wr_addr         = '0;
      ram_wr_data         = '0;
      state_in            = state_ff;
      name_sel_in         = name_sel_ff;
      char_idx_in         = char_idx_ff;
      trim_in             = trim_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_data_in         = rsp_data_ff;
      b      = req_data.data_byte;
      pos    = '0;
      ck     = '0;
      rel    = '0;
      ftype  = '0;
      flen   = '0;
      wval   = '0;
      st     = ftpc_pkg::STATUS_OK;
      notify = 1'b0;
      emit   = 1'b0;

      if (req_accept) begin
         if (req_data.frame_start) begin
            byte_position_in = '0;
            frame_length_in  = '0;
            body_length_in   = '0;
            byte_six_in      = '0;
            running_sum_in   = '0;
            framing_good_in  = 1'b1;
            checksum_good_in = 1'b0;
            next_header_in   = '0;
            field_type_in    = '0;
            bytes_left_in    = '0;
            write_index_in   = '0;
            zero_written_in  = 1'b0;
            names_seen_in    = '0;
            staged_net_in    = ftpc_pkg::NET_NONE;
            entry_valid_in   = '0;
         end
         pos = byte_position_in;

         if (pos < 9'd4 || {1'b0, pos} <= {2'b0, frame_length_in} + 10'd4) begin
            if ((pos == 9'd0 || pos == 9'd1) && b != ftpc_pkg::START_BYTE) begin
               framing_good_in = 1'b0;
            end
            if (pos == 9'd3) begin
               frame_length_in = b;
            end
            if (pos >= 9'd3 && b != ftpc_pkg::END_BYTE &&
                ({1'b0, pos} == {2'b0, frame_length_in} + 10'd3 ||
                 {1'b0, pos} == {2'b0, frame_length_in} + 10'd4)) begin
               framing_good_in = 1'b0;
            end
            if (pos == 9'd6) begin
               byte_six_in = b;
            end
            if (pos == 9'd7) begin
               body_length_in = b;
               if (b == 8'd0) begin
                  checksum_good_in = (byte_six_in == 8'd0);
               end
            end
            if (pos >= 9'd7) begin
               ck = {1'b0, body_length_in} + 9'd6;
               if (pos == ck) begin
                  checksum_good_in = (b == running_sum_in);
               end else if (pos < ck) begin
                  running_sum_in = running_sum_in + b;
               end
            end
            if (pos >= 9'd9 && staged_net_in == ftpc_pkg::NET_PENDING) begin
               staged_net_in = (b == ftpc_pkg::NET_ON_VAL) ? ftpc_pkg::NET_ON
                                                            : ftpc_pkg::NET_OFF;
            end

            // field walk
            if (pos >= 9'd8) begin
               rel = pos - 9'd8;
               if (bytes_left_in != 5'd0) begin
                  if (field_type_in <= ftpc_pkg::FIELD_SITE && write_index_in < CHARS_W5)
                  begin
                     wval = (write_index_in != 5'd0 && zero_written_in) ? 8'h00 : b;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = {field_type_in[0], write_index_in[IW-1:0]};
                     ram_wr_data = wval;
                     entry_valid_in[ram_wr_addr] = 1'b1;
                     zero_written_in = (wval == 8'h00);
                  end
                  if (write_index_in != 5'd31) begin
                     write_index_in = write_index_in + 5'd1;
                  end
                  bytes_left_in = bytes_left_in - 5'd1;
               end else if (rel == next_header_in &&
                            {1'b0, next_header_in} + 10'd2 < {2'b0, body_length_in}) begin
                  ftype          = b[7:ftpc_pkg::TYPE_SHIFT];
                  flen           = b[4:0] & ftpc_pkg::LEN_MASK;
                  field_type_in  = ftype;
                  bytes_left_in  = flen;
                  write_index_in = '0;
                  next_header_in = next_header_in + {4'd0, flen} + 9'd1;
                  if (ftype <= ftpc_pkg::FIELD_SITE) begin
                     // the entry at the field length reads as zero
                     if (flen < CHARS_W5) begin
                        entry_valid_in[{ftype[0], flen[IW-1:0]}] = 1'b0;
                     end
                     names_seen_in[ftype[0]] = 1'b1;
                  end else if (ftype == ftpc_pkg::FIELD_NET) begin
                     staged_net_in = ftpc_pkg::NET_PENDING;
                  end
               end
            end

            emit = pos >= 9'd4 && {1'b0, pos} == {2'b0, frame_length_in} + 10'd4;
         end

         if (byte_position_in < ftpc_pkg::POS_MAX) begin
            byte_position_in = byte_position_in + 9'd1;
         end

         // frame status at the last byte
         if (emit) begin
            if (!framing_good_in) begin
               st = ftpc_pkg::STATUS_FRAMING;
            end else if (checksum_good_in) begin
               st = ftpc_pkg::STATUS_OK;
               failure_notified_in = 1'b0;
            end else begin
               st = ftpc_pkg::STATUS_CHECKSUM;
               notify = !failure_notified_in;
               failure_notified_in = 1'b1;
            end
            if (st == ftpc_pkg::STATUS_OK && (staged_net_in == ftpc_pkg::NET_OFF ||
                                              staged_net_in == ftpc_pkg::NET_ON)) begin
               committed_net_in = (staged_net_in == ftpc_pkg::NET_ON);
            end
            rsp_valid_in               = 1'b1;
            rsp_data_in.kind           = ftpc_pkg::KIND_STATUS;
            rsp_data_in.char_index     = '0;
            rsp_data_in.char_value     = '0;
            rsp_data_in.status         = st;
            rsp_data_in.net_enabled    = committed_net_in;
            rsp_data_in.notify_failure = notify;
            rsp_data_in.last_result    = !(st == ftpc_pkg::STATUS_OK && names_seen_in != 2'd0);
            if (st == ftpc_pkg::STATUS_OK && names_seen_in != 2'd0) begin
               name_sel_in = !names_seen_in[0];
               char_idx_in = LAST_IDX;
               trim_in     = '0;
               state_in    = (NAME_CHARS > 1) ? ST_SCAN_RD : ST_OUT_RD;
               if (NAME_CHARS == 1) begin
                  char_idx_in = '0;
               end
            end
         end
      end

      // name burst: trim scan downward, then characters upward
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (stored_char == ftpc_pkg::SPACE_CHAR && char_idx_ff > IW'(1)) begin
               char_idx_in = char_idx_ff - IW'(1);
               state_in    = ST_SCAN_RD;
            end else begin
               // trailing spaces reaching index 1 leave only index 0 untouched
               trim_in     = (stored_char == ftpc_pkg::SPACE_CHAR) ? '0 : char_idx_ff;
               char_idx_in = '0;
               state_in    = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.kind           = name_sel_ff ? ftpc_pkg::KIND_SITE
                                                        : ftpc_pkg::KIND_USER;
               rsp_data_in.char_index     = 4'(char_idx_ff);
               rsp_data_in.char_value     = (char_idx_ff > trim_ff) ? 8'h00 : stored_char;
               rsp_data_in.status         = ftpc_pkg::STATUS_OK;
               rsp_data_in.net_enabled    = committed_net_ff;
               rsp_data_in.notify_failure = 1'b0;
               rsp_data_in.last_result    = (char_idx_ff == LAST_IDX) &&
                                            (name_sel_ff || !names_seen_ff[1]);
               if (char_idx_ff == LAST_IDX) begin
                  if (!name_sel_ff && names_seen_ff[1]) begin
                     name_sel_in = 1'b1;
                     char_idx_in = (NAME_CHARS > 1) ? LAST_IDX : '0;
                     trim_in     = '0;
                     state_in    = (NAME_CHARS > 1) ? ST_SCAN_RD : ST_OUT_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  char_idx_in = char_idx_ff + IW'(1);
                  state_in    = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff    <= '0;
         frame_length_ff     <= '0;
         body_length_ff      <= '0;
         byte_six_ff         <= '0;
         running_sum_ff      <= '0;
         framing_good_ff     <= 1'b1;
         checksum_good_ff    <= 1'b0;
         next_header_ff      <= '0;
         field_type_ff       <= '0;
         bytes_left_ff       <= '0;
         write_index_ff      <= '0;
         zero_written_ff     <= 1'b0;
         names_seen_ff       <= '0;
         staged_net_ff       <= ftpc_pkg::NET_NONE;
         committed_net_ff    <= 1'b0;
         failure_notified_ff <= 1'b0;
         entry_valid_ff      <= '0;
         state_ff            <= ST_IDLE;
         name_sel_ff         <= 1'b0;
         char_idx_ff         <= '0;
         trim_ff             <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         byte_position_ff    <= byte_position_in;
         frame_length_ff     <= frame_length_in;
         body_length_ff      <= body_length_in;
         byte_six_ff         <= byte_six_in;
         running_sum_ff      <= running_sum_in;
         framing_good_ff     <= framing_good_in;
         checksum_good_ff    <= checksum_good_in;
         next_header_ff      <= next_header_in;
         field_type_ff       <= field_type_in;
         bytes_left_ff       <= bytes_left_in;
         write_index_ff      <= write_index_in;
         zero_written_ff     <= zero_written_in;
         names_seen_ff       <= names_seen_in;
         staged_net_ff       <= staged_net_in;
         committed_net_ff    <= committed_net_in;
         failure_notified_ff <= failure_notified_in;
         entry_valid_ff      <= entry_valid_in;
         state_ff            <= state_in;
         name_sel_ff         <= name_sel_in;
         char_idx_ff         <= char_idx_in;
         trim_ff             <= trim_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: sv/ftpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ftpc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire ftpc_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ftpc_pkg::rsp_type rsp_data
);

   // stalled input holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input waits while a burst is unfinished
   a_burst_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> req_stall)
      else $error("input taken inside a result burst");

   // character results carry no status
   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ftpc_pkg::KIND_STATUS |->
         rsp_data.status == ftpc_pkg::STATUS_OK && !rsp_data.notify_failure)
      else $error("character result with status");

   // status results carry no character
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == ftpc_pkg::KIND_STATUS |->
         rsp_data.char_index == 4'd0 && rsp_data.char_value == 8'd0)
      else $error("status result with character");

endmodule

bind framed_tlv_packet_checker ftpc_checker u_ftpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
